@@ rtl/core/fcull_pkg.sv @@
// fcull_pkg: shared constants, types and helpers for the frustum cull test block.
// No dependencies; imported by every other file of the block but fcull_rsp_if.
package fcull_pkg;

   localparam int COORD_BITS  = 16;             // coordinate width, 8..24
   localparam int PLANE_COUNT = 6;              // planes tested, 1..6
   localparam int NUM_REGS    = 6;              // plane registers on the CSR port
   localparam int NORM_BITS   = 16;             // a, b, c (Q2.14) and d widths
   localparam int FRAC_BITS   = 14;
   localparam int REG_BITS    = 64;
   localparam int IDX_BITS    = 3;              // enough for NUM_REGS
   localparam int ADDR_BITS   = IDX_BITS + 3;   // 8-byte register stride
   localparam int RAD_BITS    = COORD_BITS - 1;
   localparam int PROD_BITS   = NORM_BITS + COORD_BITS;
   localparam int SUM_BITS    = ((COORD_BITS > NORM_BITS) ? COORD_BITS : NORM_BITS) + 18;

   typedef enum logic [1:0] {
      OP_POINT  = 2'd0,
      OP_SPHERE = 2'd1,
      OP_BOX    = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [NORM_BITS-1:0]  norm_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [SUM_BITS-1:0]   sum_type;
   typedef logic [RAD_BITS-1:0]          rad_type;
   typedef logic [REG_BITS-1:0]          plane_type;

   // Stage enables and mode of the item sitting in stage 2.
   typedef struct packed {
      logic en2;
      logic en3;
      logic en4;
      logic box;
      logic sphere;
   } pipe_ctl_type;

   // Field k of a packed plane word: 0 = a (top bits) .. 3 = d (low bits).
   function automatic norm_type plane_field(input plane_type pl, input logic [1:0] k);
      norm_type f;
      f = norm_type'(pl[(3 - k) * NORM_BITS +: NORM_BITS]);
      return f;
   endfunction

endpackage

@@ rtl/core/fcull_req_if.sv @@
// fcull_req_if: input channel of the frustum cull test block (valid/ready).
// Depends on fcull_pkg.
interface fcull_req_if;
   import fcull_pkg::*;

   logic      valid;
   logic      ready;
   logic [1:0] operation;
   coord_type low_x;
   coord_type low_y;
   coord_type low_z;
   coord_type high_x;
   coord_type high_y;
   coord_type high_z;
   rad_type   radius;

   modport source (output valid, operation, low_x, low_y, low_z, high_x, high_y, high_z,
                   radius, input ready);
   modport sink   (input valid, operation, low_x, low_y, low_z, high_x, high_y, high_z,
                   radius, output ready);
endinterface

@@ rtl/core/fcull_rsp_if.sv @@
// fcull_rsp_if: result channel of the frustum cull test block (valid/ready).
// No dependencies.
interface fcull_rsp_if;
   logic valid;
   logic ready;
   logic outside;

   modport source (output valid, outside, input ready);
   modport sink   (input valid, outside, output ready);
endinterface

@@ rtl/core/fcull_plane.sv @@
// fcull_plane: three-stage distance datapath for one frustum plane.
// Depends on fcull_pkg; stage valids live in the top level.
module fcull_plane (
   input  logic                      clock,
   input  fcull_pkg::pipe_ctl_type   ctl,
   input  fcull_pkg::plane_type      plane,
   input  fcull_pkg::coord_type      lo_x,
   input  fcull_pkg::coord_type      lo_y,
   input  fcull_pkg::coord_type      lo_z,
   input  fcull_pkg::coord_type      hi_x,
   input  fcull_pkg::coord_type      hi_y,
   input  fcull_pkg::coord_type      hi_z,
   input  fcull_pkg::rad_type        rad,
   output logic                      behind
);
   import fcull_pkg::*;

   norm_type coef_a, coef_b, coef_c, coef_d;
   prod_type plx_ff, ply_ff, plz_ff, phx_ff, phy_ff, phz_ff;
   prod_type sel_x, sel_y, sel_z;
   sum_type  sum_xy_ff, sum_xy_in, sum_z_ff, sum_z_in, total;
   logic     behind_ff;

   assign coef_a = plane_field(plane, 2'd0);
   assign coef_b = plane_field(plane, 2'd1);
   assign coef_c = plane_field(plane, 2'd2);
   assign coef_d = plane_field(plane, 2'd3);

   // Stage 2: both corner products per axis.
   always_ff @(posedge clock) begin
      if (ctl.en2) begin
         plx_ff <= prod_type'(coef_a) * prod_type'(lo_x);
         ply_ff <= prod_type'(coef_b) * prod_type'(lo_y);
         plz_ff <= prod_type'(coef_c) * prod_type'(lo_z);
         phx_ff <= prod_type'(coef_a) * prod_type'(hi_x);
         phy_ff <= prod_type'(coef_b) * prod_type'(hi_y);
         phz_ff <= prod_type'(coef_c) * prod_type'(hi_z);
      end
   end

   // Stage 3: box uses the farthest-forward corner (per-axis max), else the low point.
   always_comb begin
      sel_x = (ctl.box && (phx_ff > plx_ff)) ? phx_ff : plx_ff;
      sel_y = (ctl.box && (phy_ff > ply_ff)) ? phy_ff : ply_ff;
      sel_z = (ctl.box && (phz_ff > plz_ff)) ? phz_ff : plz_ff;
      sum_xy_in = sum_type'(sel_x) + sum_type'(sel_y);
      sum_z_in  = sum_type'(sel_z) + (sum_type'(coef_d) <<< FRAC_BITS)
                + (ctl.sphere ? (sum_type'(rad) <<< FRAC_BITS) : sum_type'(0));
   end

   always_ff @(posedge clock) begin
      if (ctl.en3) begin
         sum_xy_ff <= sum_xy_in;
         sum_z_ff  <= sum_z_in;
      end
   end

   // Stage 4: sign of the full distance.
   assign total = sum_xy_ff + sum_z_ff;

   always_ff @(posedge clock) begin
      if (ctl.en4) begin
         behind_ff <= total[SUM_BITS-1];
      end
   end

   assign behind = behind_ff;

endmodule

@@ rtl/core/frustum_cull_test_top.sv @@
// frustum_cull_test_top: six-plane view frustum cull test, one primitive per cycle unless stalled.
// Depends on fcull_pkg, fcull_req_if, fcull_rsp_if and fcull_plane.
//
//   channel   role     handshake               payload
//   req_ch    in       valid/ready             operation, low_xyz, high_xyz, radius
//   rsp_ch    out      valid/ready             outside
//   csr (APB) in       psel/penable/pwrite     paddr, pwdata -> prdata, pready = 1
//
// The result becomes valid once the item has gone through the five register stages
// (input, products, partial sums, sign, output); the input register loads at the accept
// edge. One item per cycle is sustained while rsp_ch is ready.
// Each stage holds while the stage after it is full and stalled; a bubble is filled
// at once, so a rsp_ch stall backs up stage by stage and loses nothing.
// Synchronous active-high reset clears stage valids and all six planes to zero.
// The user writes planes via the CSR port only while no item is in flight; unenforced.
module frustum_cull_test_top (
   input  logic                             clock,
   input  logic                             reset,
   fcull_req_if.sink                        req_ch,
   fcull_rsp_if.source                      rsp_ch,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [fcull_pkg::ADDR_BITS-1:0]  paddr,
   input  logic [fcull_pkg::REG_BITS-1:0]   pwdata,
   output logic [fcull_pkg::REG_BITS-1:0]   prdata,
   output logic                             pready
);
   import fcull_pkg::*;

   // ---------------- plane registers (APB) ----------------
   plane_type            plane_ff [NUM_REGS];
   logic [IDX_BITS-1:0]  csr_idx;
   logic                 csr_hit;

   assign pready  = 1'b1;
   assign csr_idx = paddr[ADDR_BITS-1 -: IDX_BITS];
   assign csr_hit = (32'(csr_idx) < NUM_REGS);
   assign prdata  = csr_hit ? plane_ff[csr_idx] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) plane_ff[i] <= '0;
      end else if (psel && penable && pwrite && pready && csr_hit) begin
         plane_ff[csr_idx] <= pwdata;
      end
   end

   // ---------------- pipeline control ----------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   // A stage may load when it is empty or its item moves on this cycle.
   always_comb begin
      rdy5 = !v5_ff || rsp_ch.ready;
      rdy4 = !v4_ff || rdy5;
      rdy3 = !v3_ff || rdy4;
      rdy2 = !v2_ff || rdy3;
      rdy1 = !v1_ff || rdy2;
   end

   assign req_ch.ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_ch.valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   // ---------------- stage 1: input register ----------------
   op_type    op1_ff, op2_ff, op3_ff, op4_ff;
   coord_type lx1_ff, ly1_ff, lz1_ff, hx1_ff, hy1_ff, hz1_ff;
   rad_type   rad1_ff, rad2_ff;

   always_ff @(posedge clock) begin
      if (rdy1 && req_ch.valid) begin
         op1_ff  <= op_type'(req_ch.operation);
         lx1_ff  <= req_ch.low_x;
         ly1_ff  <= req_ch.low_y;
         lz1_ff  <= req_ch.low_z;
         hx1_ff  <= req_ch.high_x;
         hy1_ff  <= req_ch.high_y;
         hz1_ff  <= req_ch.high_z;
         rad1_ff <= req_ch.radius;
      end
   end

   // Side data that rides along with the plane datapaths.
   always_ff @(posedge clock) begin
      if (rdy2) begin
         op2_ff  <= op1_ff;
         rad2_ff <= rad1_ff;
      end
      if (rdy3) op3_ff <= op2_ff;
      if (rdy4) op4_ff <= op3_ff;
   end

   // ---------------- stages 2-4: per-plane distance ----------------
   pipe_ctl_type            ctl;
   logic [PLANE_COUNT-1:0]  behind;

   assign ctl.en2    = rdy2;
   assign ctl.en3    = rdy3;
   assign ctl.en4    = rdy4;
   assign ctl.box    = (op2_ff == OP_BOX);
   assign ctl.sphere = (op2_ff == OP_SPHERE);

   for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
      fcull_plane u_plane (
         .clock  (clock),
         .ctl    (ctl),
         .plane  (plane_ff[p]),
         .lo_x   (lx1_ff),
         .lo_y   (ly1_ff),
         .lo_z   (lz1_ff),
         .hi_x   (hx1_ff),
         .hi_y   (hy1_ff),
         .hi_z   (hz1_ff),
         .rad    (rad2_ff),
         .behind (behind[p])
      );
   end

   // ---------------- stage 5: output register ----------------
   // Culled when behind any plane; the spare op code never culls.
   logic outside_ff;

   always_ff @(posedge clock) begin
      if (rdy5 && v4_ff) begin
         outside_ff <= (op4_ff != OP_NONE) && (|behind);
      end
   end

   assign rsp_ch.valid   = v5_ff;
   assign rsp_ch.outside = outside_ff;

   // ---------------- assertions ----------------
   // Input back-pressure only when every stage is full.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (v1_ff && v2_ff && v3_ff && v4_ff && v5_ff))
      else $error("input stalled with a bubble in the pipeline");

   // The spare op code must never produce a cull.
   a_none_not_culled: assert property (@(posedge clock) disable iff (reset)
      (rdy5 && v4_ff && (op4_ff == OP_NONE)) |=> !rsp_ch.outside)
      else $error("unused operation reported outside");

   // A stalled stage keeps its item.
   a_hold_v3: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !rdy4) |=> v3_ff)
      else $error("stage 3 item dropped during stall");

endmodule

@@ tb/frustum_cull_test_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for frustum_cull_test_top: directed rows, then random primitives
// against a built-in cull predictor. Depends on fcull_pkg, fcull_req_if and fcull_rsp_if.
module frustum_cull_test_top_tb;
   import fcull_pkg::*;

   localparam int PIPE_DEPTH      = 4;        // scales the final wait for stray results
   localparam int CYCLE_LIMIT     = 200000;
   localparam int RANDOM_PHASES   = 5;
   localparam int ITEMS_PER_PHASE = 340;
   localparam int HOLD_AT         = 300;      // results seen before the long back-pressure
   localparam int HOLD_CYCLES     = 64;

   typedef enum logic [1:0] {
      WANT_CLEAR,
      WANT_CULLED,
      WANT_PREDICTED
   } want_type;

   typedef enum logic {
      PLANES_RESET,
      PLANES_AXIS
   } plane_set_type;

   typedef struct {
      op_type    op;
      coord_type lo_x, lo_y, lo_z;
      coord_type hi_x, hi_y, hi_z;
      rad_type   radius;
   } prim_type;

   typedef struct {
      plane_set_type planes;
      prim_type      prim;
      want_type      want;
   } cull_row_type;

   typedef struct {
      logic outside;
      int   tag;
   } verdict_type;

   // Axis-aligned test frustum: x >= -100, y >= 0, z <= 1000, x <= 500; near and far
   // stay all-zero, so they can never cull anything.
   localparam plane_type AXIS_PLANES [NUM_REGS] = '{
      {16'h4000, 16'h0000, 16'h0000, 16'd100},
      {16'h0000, 16'h4000, 16'h0000, 16'h0000},
      {16'h0000, 16'h0000, 16'hC000, 16'd1000},
      {16'hC000, 16'h0000, 16'h0000, 16'd500},
      64'h0,
      64'h0
   };

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 psel;
   logic                 penable;
   logic                 pwrite;
   logic [ADDR_BITS-1:0] paddr;
   logic [REG_BITS-1:0]  pwdata;
   logic [REG_BITS-1:0]  prdata;
   logic                 pready;

   fcull_req_if req_ch ();
   fcull_rsp_if rsp_ch ();

   frustum_cull_test_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Shadow of the plane registers, the queue of pending verdicts and run bookkeeping.
   plane_type     plane_copy [NUM_REGS];
   verdict_type   verdict_q [$];
   cull_row_type  dir_rows [$];
   int            errors = 0;
   int            results_seen = 0;
   int            tag_count = 0;
   int            cycles = 0;
   bit            steady = 1'b0;     // set: neither side idles

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results pending", $time, verdict_q.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   //------------------------------------------------------------------------
   // Predictor
   //------------------------------------------------------------------------

   // Exact signed distance in units of 2^-14: a, b, c are Q2.14, d is an integer.
   function automatic longint plane_distance(input plane_type pl, input longint x,
                                             input longint y, input longint z);
      norm_type a, b, c, d;
      a = pl[63:48];
      b = pl[47:32];
      c = pl[31:16];
      d = pl[15:0];
      return longint'(a) * x + longint'(b) * y + longint'(c) * z
             + longint'(d) * (longint'(1) << FRAC_BITS);
   endfunction

   // Culled when some plane has the point, the whole sphere or all eight box corners
   // strictly behind it. Sphere touching a plane is kept.
   function automatic logic predict_culled(input prim_type pr);
      longint lo [3];
      longint hi [3];
      longint x, y, z;
      logic   culled;
      logic   behind;
      culled = 1'b0;
      lo[0] = pr.lo_x;  lo[1] = pr.lo_y;  lo[2] = pr.lo_z;
      hi[0] = pr.hi_x;  hi[1] = pr.hi_y;  hi[2] = pr.hi_z;
      for (int p = 0; p < PLANE_COUNT; p++) begin
         case (pr.op)
            OP_POINT: begin
               if (plane_distance(plane_copy[p], lo[0], lo[1], lo[2]) < 0)
                  culled = 1'b1;
            end
            OP_SPHERE: begin
               if (plane_distance(plane_copy[p], lo[0], lo[1], lo[2])
                   + longint'(pr.radius) * (longint'(1) << FRAC_BITS) < 0)
                  culled = 1'b1;
            end
            OP_BOX: begin
               behind = 1'b1;
               // Corners mix low and high per axis; an inverted box is taken as given.
               for (int k = 0; k < 8; k++) begin
                  x = ((k & 1) != 0) ? hi[0] : lo[0];
                  y = ((k & 2) != 0) ? hi[1] : lo[1];
                  z = ((k & 4) != 0) ? hi[2] : lo[2];
                  if (plane_distance(plane_copy[p], x, y, z) >= 0)
                     behind = 1'b0;
               end
               if (behind)
                  culled = 1'b1;
            end
            default: ;   // unused code: no test, never culled
         endcase
      end
      return culled;
   endfunction

   //------------------------------------------------------------------------
   // Stimulus helpers
   //------------------------------------------------------------------------

   function automatic cull_row_type row(input plane_set_type ps, input op_type op,
                                        input int lx, input int ly, input int lz,
                                        input int hx, input int hy, input int hz,
                                        input int r, input want_type w);
      cull_row_type cr;
      cr.planes      = ps;
      cr.prim.op     = op;
      cr.prim.lo_x   = coord_type'(lx);
      cr.prim.lo_y   = coord_type'(ly);
      cr.prim.lo_z   = coord_type'(lz);
      cr.prim.hi_x   = coord_type'(hx);
      cr.prim.hi_y   = coord_type'(hy);
      cr.prim.hi_z   = coord_type'(hz);
      cr.prim.radius = rad_type'(r);
      cr.want        = w;
      return cr;
   endfunction

   // Mostly full-range values, with the extremes and a band around zero mixed in.
   function automatic coord_type rand_coord();
      case ($urandom_range(0, 9))
         0:       return {1'b1, {(COORD_BITS-1){1'b0}}};
         1:       return {1'b0, {(COORD_BITS-1){1'b1}}};
         2, 3:    return coord_type'(int'($urandom_range(0, 400)) - 200);
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic rad_type rand_radius();
      case ($urandom_range(0, 7))
         0:       return '1;
         1:       return '0;
         2, 3:    return rad_type'($urandom_range(0, 300));
         default: return rad_type'($urandom);
      endcase
   endfunction

   // APB write: setup cycle, then access; the register takes the value at the edge
   // that closes the access phase.
   task automatic csr_write(input int idx, input plane_type value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_BITS'(idx * 8);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (idx < NUM_REGS)
         plane_copy[idx] = value;
   endtask

   task automatic csr_read(input int idx, output plane_type value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= ADDR_BITS'(idx * 8);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      value = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic check_planes();
      plane_type got;
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_read(i, got);
         if (got !== plane_copy[i]) begin
            errors++;
            $display("%0t: plane %0d readback expected %h actual %h",
                     $time, i, plane_copy[i], got);
         end
      end
   endtask

   // Offer one primitive; valid stays high after the accept so back-to-back items
   // go out without a gap unless an idle cycle is drawn.
   task automatic send_prim(input prim_type pr, input want_type want);
      verdict_type v;
      if (!steady && $urandom_range(0, 99) < 10) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.operation <= pr.op;
      req_ch.low_x     <= pr.lo_x;
      req_ch.low_y     <= pr.lo_y;
      req_ch.low_z     <= pr.lo_z;
      req_ch.high_x    <= pr.hi_x;
      req_ch.high_y    <= pr.hi_y;
      req_ch.high_z    <= pr.hi_z;
      req_ch.radius    <= pr.radius;
      do @(posedge clock); while (!req_ch.ready);
      case (want)
         WANT_CLEAR:  v.outside = 1'b0;
         WANT_CULLED: v.outside = 1'b1;
         default:     v.outside = predict_culled(pr);
      endcase
      v.tag = tag_count++;
      verdict_q.push_back(v);
   endtask

   // Stop offering and wait until every accepted item has its result back.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (verdict_q.size() != 0)
         @(posedge clock);
   endtask

   //------------------------------------------------------------------------
   // Result side: random stalls, one long hold-off, and the check against the
   // oldest pending verdict.
   //------------------------------------------------------------------------
   initial begin : result_sink
      verdict_type v;
      int          hold_left;
      bit          held;
      hold_left    = 0;
      held         = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (verdict_q.size() == 0) begin
               errors++;
               $display("%0t: expected no result, actual outside=%0b",
                        $time, rsp_ch.outside);
            end else begin
               v = verdict_q.pop_front();
               if (rsp_ch.outside !== v.outside) begin
                  errors++;
                  $display("%0t: item %0d outside expected %0b actual %0b",
                           $time, v.tag, v.outside, rsp_ch.outside);
               end
            end
         end
         // Long hold-off once: the pipeline fills and the input side must stall.
         if (!held && results_seen >= HOLD_AT) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 10);
         end
      end
   end

   //------------------------------------------------------------------------
   // Main sequence
   //------------------------------------------------------------------------
   initial begin : stimulus
      prim_type      pr;
      plane_set_type active_set;
      int            n;

      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.operation = OP_POINT;
      req_ch.low_x     = '0;
      req_ch.low_y     = '0;
      req_ch.low_z     = '0;
      req_ch.high_x    = '0;
      req_ch.high_y    = '0;
      req_ch.high_z    = '0;
      req_ch.radius    = '0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      for (int i = 0; i < NUM_REGS; i++)
         plane_copy[i] = '0;
      active_set = PLANES_RESET;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_planes();   // all planes read zero after reset

      // Directed rows. With all-zero planes nothing can be culled; the axis set
      // exercises each plane, sphere touching, the box y corners and inverted boxes.
      dir_rows.push_back(row(PLANES_RESET, OP_POINT,  0, 0, 0, 0, 0, 0, 0, WANT_CLEAR));
      dir_rows.push_back(row(PLANES_RESET, OP_POINT,  -32768, -32768, -32768,
                             0, 0, 0, 0, WANT_CLEAR));
      dir_rows.push_back(row(PLANES_RESET, OP_SPHERE, 32767, 32767, 32767,
                             0, 0, 0, 32767, WANT_CLEAR));
      dir_rows.push_back(row(PLANES_RESET, OP_BOX,    -32768, -32768, -32768,
                             32767, 32767, 32767, 0, WANT_CLEAR));
      dir_rows.push_back(row(PLANES_RESET, OP_NONE,   -32768, -32768, -32768,
                             -32768, -32768, -32768, 32767, WANT_CLEAR));
      dir_rows.push_back(row(PLANES_AXIS, OP_POINT,  0, 0, 0, 0, 0, 0, 0, WANT_CLEAR));
      dir_rows.push_back(row(PLANES_AXIS, OP_POINT,  -101, 0, 0, 0, 0, 0, 0, WANT_CULLED));
      dir_rows.push_back(row(PLANES_AXIS, OP_POINT,  -100, 0, 0, 0, 0, 0, 0, WANT_CLEAR));
      dir_rows.push_back(row(PLANES_AXIS, OP_POINT,  0, -1, 0, 0, 0, 0, 0, WANT_CULLED));
      dir_rows.push_back(row(PLANES_AXIS, OP_POINT,  0, 0, 1001, 0, 0, 0, 0, WANT_CULLED));
      dir_rows.push_back(row(PLANES_AXIS, OP_POINT,  501, 0, 0, 0, 0, 0, 0, WANT_CULLED));
      // sphere just touching the y plane stays visible
      dir_rows.push_back(row(PLANES_AXIS, OP_SPHERE, 0, -10, 0, 0, 0, 0, 10, WANT_CLEAR));
      dir_rows.push_back(row(PLANES_AXIS, OP_SPHERE, 0, -11, 0, 0, 0, 0, 10, WANT_CULLED));
      dir_rows.push_back(row(PLANES_AXIS, OP_SPHERE, 0, -32768, 0, 0, 0, 0, 32767,
                             WANT_CULLED));
      dir_rows.push_back(row(PLANES_AXIS, OP_SPHERE, 0, -32767, 0, 0, 0, 0, 32767,
                             WANT_CLEAR));
      // high y must come from high_y, not high_x (high_x is negative here)
      dir_rows.push_back(row(PLANES_AXIS, OP_BOX, -50, -10, 0, -20, 5, 0, 0, WANT_CLEAR));
      dir_rows.push_back(row(PLANES_AXIS, OP_BOX, -50, -10, 0, -20, -1, 0, 0, WANT_CULLED));
      // inverted boxes: corners used as given
      dir_rows.push_back(row(PLANES_AXIS, OP_BOX, 0, 5, 0, -300, -5, 0, 0, WANT_CLEAR));
      dir_rows.push_back(row(PLANES_AXIS, OP_BOX, -200, 5, 0, -300, -5, 0, 0, WANT_CULLED));
      dir_rows.push_back(row(PLANES_AXIS, OP_NONE, -32768, -32768, -32768,
                             0, 0, 0, 0, WANT_CLEAR));
      dir_rows.push_back(row(PLANES_AXIS, OP_BOX, -32768, -32768, -32768,
                             32767, 32767, 32767, 0, WANT_CLEAR));
      dir_rows.push_back(row(PLANES_AXIS, OP_POINT, 32767, 32767, 32767,
                             0, 0, 0, 0, WANT_CULLED));
      dir_rows.push_back(row(PLANES_AXIS, OP_NONE, 32767, 32767, 32767,
                             32767, 32767, 32767, 32767, WANT_CLEAR));
      dir_rows.push_back(row(PLANES_AXIS, OP_SPHERE, 123, 45, -67, 0, 0, 0, 89,
                             WANT_PREDICTED));

      foreach (dir_rows[i]) begin
         if (dir_rows[i].planes != active_set) begin
            drain();
            for (int p = 0; p < NUM_REGS; p++)
               csr_write(p, AXIS_PLANES[p]);
            active_set = dir_rows[i].planes;
         end
         send_prim(dir_rows[i].prim, dir_rows[i].want);
      end
      drain();

      // Writes past the last register must leave every plane untouched.
      csr_write(NUM_REGS, '1);
      csr_write(NUM_REGS + 1, 64'h8000_7FFF_8000_7FFF);
      check_planes();

      // Random phases. The first two load the plane extremes everywhere, the rest a mix
      // of zero, extreme and random planes.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         drain();
         for (int p = 0; p < NUM_REGS; p++) begin
            if (ph == 0)
               csr_write(p, 64'h7FFF_7FFF_7FFF_7FFF);
            else if (ph == 1)
               csr_write(p, 64'h8000_8000_8000_8000);
            else begin
               case ($urandom_range(0, 7))
                  0:       csr_write(p, '0);
                  1:       csr_write(p, '1);
                  2:       csr_write(p, 64'h7FFF_8000_7FFF_8000);
                  3:       csr_write(p, 64'h8000_7FFF_8000_7FFF);
                  default: csr_write(p, {$urandom, $urandom});
               endcase
            end
         end
         check_planes();
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            // one stretch with both sides running flat out
            steady = (ph == 2) && (i < 300);
            n = $urandom_range(0, 19);
            pr.op     = (n == 0) ? OP_NONE : op_type'(n % 3);
            pr.lo_x   = rand_coord();
            pr.lo_y   = rand_coord();
            pr.lo_z   = rand_coord();
            pr.hi_x   = rand_coord();
            pr.hi_y   = rand_coord();
            pr.hi_z   = rand_coord();
            pr.radius = rand_radius();
            send_prim(pr, WANT_PREDICTED);
         end
         steady = 1'b0;
      end
      drain();

      // Let any stray result show up before the verdict.
      repeat (PIPE_DEPTH * 4) @(posedge clock);
      if (errors == 0 && verdict_q.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/fcull_pkg.sv
rtl/core/fcull_req_if.sv
rtl/core/fcull_rsp_if.sv
rtl/core/fcull_plane.sv
rtl/core/frustum_cull_test_top.sv
tb/frustum_cull_test_top_tb.sv
